// ----- rtl/tgr_pkg.sv -----
// Package for the timed gate with attack and release ramps.
// Holds widths, the gain constants, the gate phase, register codes and the config write bundle.
// No dependencies; every other file imports it.
package tgr_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 32;
  localparam int GAIN_BITS    = 17;
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int PROD_BITS    = SAMPLE_BITS + GAIN_BITS + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(65536);
  localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_ATTACK,
    PH_DECAY,
    PH_ALWAYS_ON,
    PH_ALWAYS_OFF
  } phase_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ON_SAMPLE,
    CFG_OFF_SAMPLE,
    CFG_ATTACK_STEP,
    CFG_RELEASE_STEP
  } cfg_idx_e;

  typedef struct packed {
    logic                    we;
    cfg_idx_e                idx;
    logic [CFG_BITS-1:0]     data;
  } cfg_wr_t;

endpackage

// ----- rtl/tgr_in_if.sv -----
// Input channel of the timed gate: valid/ready handshake and one audio sample per item.
// Depends on tgr_pkg.
interface tgr_in_if import tgr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/tgr_out_if.sv -----
// Output channel of the timed gate: valid/ready handshake, scaled sample and applied gain.
// Depends on tgr_pkg.
interface tgr_out_if import tgr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic        [GAIN_BITS-1:0]   gain_now;

  modport source (output valid, output sample_out, output gain_now, input ready);
  modport sink   (input valid, input sample_out, input gain_now, output ready);
endinterface

// ----- rtl/tgr_gain_ctrl.sv -----
// Gain control of the timed gate: config registers, sample counter, gain and phase.
// Gives the gain for the item advanced this cycle. Depends on tgr_pkg.
module tgr_gain_ctrl import tgr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_wr_t              cfg_i,
  input  logic                 step_i,
  output logic [GAIN_BITS-1:0] gain_o
);

  logic [COUNT_BITS-1:0] on_q, on_d, off_q, off_d;
  logic [GAIN_BITS-1:0]  att_q, att_d, rel_q, rel_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [GAIN_BITS-1:0]  gain_q, gain_d;
  phase_e                phase_q, phase_d;

  logic [GAIN_BITS-1:0]  gain_upd;
  phase_e                phase_upd;
  logic [COUNT_BITS-1:0] cnt_upd;
  logic [GAIN_BITS-1:0]  step_a, step_r;
  logic [GAIN_BITS:0]    gain_sum;

  assign step_a   = (att_q == GAIN_ZERO) ? GAIN_ONE : att_q;
  assign step_r   = (rel_q == GAIN_ZERO) ? GAIN_ONE : rel_q;
  assign gain_sum = {1'b0, gain_q} + {1'b0, step_a};

  // Advance the gate by one sample
  always_comb begin
    phase_upd = phase_q;
    gain_upd  = gain_q;
    cnt_upd   = cnt_q;
    if (phase_q != PH_ALWAYS_ON && phase_q != PH_ALWAYS_OFF) begin
      if (cnt_q == on_q) begin
        phase_upd = PH_ATTACK;
      end
      if (cnt_q == off_q) begin
        phase_upd = PH_DECAY;
      end
      if (cnt_q != '1) begin
        cnt_upd = cnt_q + COUNT_BITS'(1);
      end
      if (phase_upd == PH_ATTACK) begin
        if (gain_sum >= {1'b0, GAIN_ONE}) begin
          gain_upd  = GAIN_ONE;
          phase_upd = (off_q < on_q) ? PH_ALWAYS_ON : PH_CLEAR;
        end else begin
          gain_upd = gain_sum[GAIN_BITS-1:0];
        end
      end else if (phase_upd == PH_DECAY) begin
        if (gain_q <= step_r) begin
          gain_upd  = GAIN_ZERO;
          phase_upd = (on_q < off_q) ? PH_ALWAYS_OFF : PH_CLEAR;
        end else begin
          gain_upd = gain_q - step_r;
        end
      end
    end
  end

  // Next state: register writes reload the gate, accepted items advance it
  always_comb begin
    on_d    = on_q;
    off_d   = off_q;
    att_d   = att_q;
    rel_d   = rel_q;
    cnt_d   = cnt_q;
    gain_d  = gain_q;
    phase_d = phase_q;
    if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_ON_SAMPLE:    on_d  = COUNT_BITS'(cfg_i.data);
        CFG_OFF_SAMPLE:   off_d = COUNT_BITS'(cfg_i.data);
        CFG_ATTACK_STEP:  att_d = cfg_i.data[GAIN_BITS-1:0];
        CFG_RELEASE_STEP: rel_d = cfg_i.data[GAIN_BITS-1:0];
        default: ;
      endcase
      cnt_d = '0;
      if (on_d == off_d) begin
        phase_d = PH_ALWAYS_ON;
        gain_d  = GAIN_ONE;
      end else begin
        phase_d = PH_CLEAR;
        if (on_d < off_d) begin
          gain_d = (on_d == '0) ? GAIN_ONE : GAIN_ZERO;
        end else begin
          gain_d = (off_d == '0) ? GAIN_ZERO : GAIN_ONE;
        end
      end
    end else if (step_i) begin
      cnt_d   = cnt_upd;
      gain_d  = gain_upd;
      phase_d = phase_upd;
    end
  end

  // Output: gain that applies to the item advanced now
  always_comb begin
    gain_o = gain_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= '0;
      off_q   <= '0;
      att_q   <= GAIN_ONE;
      rel_q   <= GAIN_ONE;
      cnt_q   <= '0;
      gain_q  <= GAIN_ONE;
      phase_q <= PH_ALWAYS_ON;
    end else begin
      on_q    <= on_d;
      off_q   <= off_d;
      att_q   <= att_d;
      rel_q   <= rel_d;
      cnt_q   <= cnt_d;
      gain_q  <= gain_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- rtl/timed_gate_with_ramps_core.sv -----
// Top level of the timed gate with attack and release ramps.
// Depends on tgr_pkg, tgr_in_if, tgr_out_if and tgr_gain_ctrl.
//
//   channel  | dir | payload                     | handshake
//   in_i     | in  | sample_in                   | valid/ready
//   out_o    | out | sample_out, gain_now        | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_data_i       | cfg_we_i, no wait
//
// Sustains one item per cycle unless out_o stalls; items pass the input and result registers.
// The gain is updated on acceptance, the multiply sits between the input and result registers.
// in_i.ready drops only while both stages hold items and out_o is stalled.
// Reset loads on = off = 0, so the gate starts as pass-through.
module timed_gate_with_ramps_core import tgr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  tgr_in_if.sink              in_i,
  tgr_out_if.source           out_o
);

  cfg_wr_t                       cfg;
  logic                          in_acc;
  logic [GAIN_BITS-1:0]          gain_cur;

  logic                          s1_vld_q;
  logic signed [SAMPLE_BITS-1:0] s1_smp_q;
  logic [GAIN_BITS-1:0]          s1_gain_q;
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q, out_smp_d;
  logic [GAIN_BITS-1:0]          out_gain_q;
  logic                          out_free;
  logic signed [PROD_BITS-1:0]   prod;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  tgr_gain_ctrl u_gain_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_acc),
    .gain_o (gain_cur)
  );

  // Scale: floor(sample * gain / 2^16)
  assign prod      = s1_smp_q * $signed({1'b0, s1_gain_q});
  assign out_smp_d = prod[SAMPLE_BITS+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_smp_q  <= in_i.sample_in;
      s1_gain_q <= gain_cur;
    end
    if (out_free && s1_vld_q) begin
      out_smp_q  <= out_smp_d;
      out_gain_q <= s1_gain_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.gain_now   = out_gain_q;

endmodule

// ----- rtl/tgr_checker.sv -----
// Port-level checks for timed_gate_with_ramps_core, attached by bind.
// Depends on tgr_pkg and the top level's ports.
module tgr_checker import tgr_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_i,
  input logic [GAIN_BITS-1:0]          gain_now_i
);

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gain_now_i <= GAIN_ONE)
    else $error("gain_now above unity");

  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gain_now_i == GAIN_ZERO |-> sample_out_i == '0)
    else $error("closed gate passes signal");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("item dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_out_i) && $stable(gain_now_i))
    else $error("payload changed while stalled");

endmodule

bind timed_gate_with_ramps_core tgr_checker u_tgr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_out_i (out_o.sample_out),
  .gain_now_i   (out_o.gain_now)
);
